FILE: rtl/ptsa_pkg.sv
// Shared types and constants for the pan/tilt servo aiming block.
// No dependencies; used by ptsa_cordic, ptsa_isqrt and pan_tilt_servo_aim.
`timescale 1ns / 1ps

package ptsa_pkg;

	// Payload of one input beat
	typedef struct packed {
		logic signed [15:0] x_position;
		logic signed [15:0] y_position;
	} target_t;

	// Payload of one result beat
	typedef struct packed {
		logic [15:0] pan_compare;
		logic [15:0] tilt_compare;
	} result_t;

	// Datapath widths
	localparam int DATA_W  = 64;
	localparam int ANGLE_W = 32;
	localparam int ROOT_W  = 32;
	localparam int STEP_W  = 5;
	localparam int TABLE_LEN = 24;
	localparam int OPERAND_SHIFT = 28;

	// Register map (index taken from paddr[2])
	localparam logic [0:0] REG_PLANE_DISTANCE = 1'b0;
	localparam logic [15:0] DIST_RESET = 16'd1000;

	// Compare mapping constants
	localparam logic [15:0] CENTER_COMPARE = 16'd42500;
	localparam logic signed [47:0] PAN_GAIN = 48'sd20000;
	localparam logic [63:0] INV_PI_Q32 = 64'd1367130551;
	localparam logic signed [63:0] TILT_GAIN = $signed((64'd20000 * INV_PI_Q32) >> 16);
	localparam logic signed [63:0] TILT_BIAS = $signed(((64'd2500 * INV_PI_Q32) << 16) / 64'd9);

	// atan(2^-i) in 2^-32 turns
	function automatic logic signed [ANGLE_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
		logic signed [ANGLE_W-1:0] v;
		case (idx)
			5'd0:  v = 32'sh20000000;
			5'd1:  v = 32'sh12E4051E;
			5'd2:  v = 32'sh09FB385B;
			5'd3:  v = 32'sh051111D4;
			5'd4:  v = 32'sh028B0D43;
			5'd5:  v = 32'sh0145D7E1;
			5'd6:  v = 32'sh00A2F61E;
			5'd7:  v = 32'sh00517C55;
			5'd8:  v = 32'sh0028BE53;
			5'd9:  v = 32'sh00145F2F;
			5'd10: v = 32'sh000A2F98;
			5'd11: v = 32'sh000517CC;
			5'd12: v = 32'sh00028BE6;
			5'd13: v = 32'sh000145F3;
			5'd14: v = 32'sh0000A2FA;
			5'd15: v = 32'sh0000517D;
			5'd16: v = 32'sh000028BE;
			5'd17: v = 32'sh0000145F;
			5'd18: v = 32'sh00000A30;
			5'd19: v = 32'sh00000518;
			5'd20: v = 32'sh0000028C;
			5'd21: v = 32'sh00000146;
			5'd22: v = 32'sh000000A3;
			5'd23: v = 32'sh00000051;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/ptsa_cordic.sv
// Iterative vectoring CORDIC: one micro-rotation per cycle, returns the vector angle.
// Depends on ptsa_pkg (widths, arctangent table).
`timescale 1ns / 1ps

module ptsa_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [ptsa_pkg::DATA_W-1:0]    x_init,
	input  logic signed [ptsa_pkg::DATA_W-1:0]    y_init,
	output logic                                  done,
	output logic signed [ptsa_pkg::ANGLE_W-1:0]   angle
);

	logic signed [ptsa_pkg::DATA_W-1:0]  cx_q, cy_q, dx, dy;
	logic signed [ptsa_pkg::ANGLE_W-1:0] z_q, rot;
	logic [ptsa_pkg::STEP_W-1:0]         step_q;
	logic                                run_q, done_q, last;

	// floor shifts and table lookup for the current step
	assign dx   = cy_q >>> step_q;
	assign dy   = cx_q >>> step_q;
	assign rot  = ptsa_pkg::atan_turn(step_q);
	assign last = (step_q == ptsa_pkg::STEP_W'(CORDIC_STEPS - 1));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= run_q && last;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				if (last) run_q <= 1'b0;
				step_q <= step_q + 1'b1;
			end
		end
	end

	// micro-rotation toward y = 0
	always_ff @(posedge clk) begin
		if (start) begin
			cx_q <= x_init;
			cy_q <= y_init;
			z_q  <= '0;
		end else if (run_q) begin
			if (!cy_q[ptsa_pkg::DATA_W-1]) begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				z_q  <= z_q + rot;
			end else begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				z_q  <= z_q - rot;
			end
		end
	end

	assign done  = done_q;
	assign angle = z_q;

	ap_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(run_q)) else $error("cordic done without run");
	ap_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !run_q) else $error("cordic restarted while running");
	ap_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> step_q < ptsa_pkg::STEP_W'(CORDIC_STEPS)) else $error("cordic step overrun");

endmodule

FILE: rtl/ptsa_isqrt.sv
// Digit-serial integer square root: two radicand bits in, one root bit out per cycle.
// Depends on ptsa_pkg (widths).
`timescale 1ns / 1ps

module ptsa_isqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ptsa_pkg::DATA_W-1:0]    radicand,
	output logic                           done,
	output logic [ptsa_pkg::ROOT_W-1:0]    root
);

	localparam int REM_W = ptsa_pkg::ROOT_W + 3;
	localparam int CNT_W = $clog2(ptsa_pkg::ROOT_W);

	logic [ptsa_pkg::DATA_W-1:0] rad_q;
	logic [REM_W-1:0]            rem_q;
	logic [REM_W+1:0]            rem_n, trial;
	logic [ptsa_pkg::ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        run_q, done_q, fits, last;

	// next partial remainder and trial subtrahend
	assign rem_n = {rem_q, rad_q[ptsa_pkg::DATA_W-1 -: 2]};
	assign trial = {(REM_W+2-ptsa_pkg::ROOT_W-2)'(0), root_q, 2'b01};
	assign fits  = (rem_n >= trial);
	assign last  = (cnt_q == CNT_W'(ptsa_pkg::ROOT_W - 1));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && last;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (last) run_q <= 1'b0;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// one root digit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q <= {rad_q[ptsa_pkg::DATA_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= REM_W'(rem_n - trial);
				root_q <= {root_q[ptsa_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= REM_W'(rem_n);
				root_q <= {root_q[ptsa_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

	ap_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(run_q && last)) else $error("sqrt done out of turn");
	ap_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !run_q) else $error("sqrt restarted while running");
	ap_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> rem_q <= {root_q, 1'b0}) else $error("sqrt remainder out of range");

endmodule

FILE: rtl/pan_tilt_servo_aim.sv
// Top level of the pan/tilt servo aiming block: APB register, sequencer, compare mapping.
// Depends on ptsa_pkg, ptsa_cordic and ptsa_isqrt.
`timescale 1ns / 1ps
//
// Channel   | Handshake                          | Payload
// ----------+------------------------------------+---------------------------
// input     | start & !busy                      | target (x_position, y_position)
// result    | done, one cycle, cannot stall      | result (pan_compare, tilt_compare)
// config    | psel & penable & pwrite (pready=1) | paddr, pwdata, prdata
//
// The square root (one bit per cycle) sets the span; the pan CORDIC runs beside it,
// the tilt CORDIC after it, both on one shared iterative unit.
// busy falls in the done cycle, so the next beat can be accepted at the edge that
// takes the result; no new beat is taken while an item is still in flight.
// arst_n clears control state and sets plane_distance to 1000.

module pan_tilt_servo_aim #(
	parameter int CORDIC_STEPS   = 16,
	parameter int POSITION_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ptsa_pkg::target_t  target,
	output logic               done,
	output ptsa_pkg::result_t  result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int PW = POSITION_WIDTH;
	localparam int ROOT_FRAC = (PW <= 16) ? 14 : ((PW >= 31) ? 0 : 31 - PW);
	localparam int DW = ptsa_pkg::DATA_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQR  = 3'd1;
	localparam logic [2:0] ST_ROOT = 3'd2;
	localparam logic [2:0] ST_WAIT = 3'd3;
	localparam logic [2:0] ST_TILT = 3'd4;
	localparam logic [2:0] ST_MAP  = 3'd5;

	logic [2:0]                          state_q;
	logic [15:0]                         dist_q, d_q;
	logic signed [PW-1:0]                x_q, y_q;
	logic [DW-1:0]                       x_raw, y_raw;
	logic signed [2*PW-1:0]              sqx_q;
	logic [31:0]                         sqd_q;
	logic signed [ptsa_pkg::ANGLE_W-1:0] apan_q, cord_angle;
	logic signed [DW-1:0]                tprod_s1, cord_x, cord_y, tnum;
	logic signed [47:0]                  pan_sum;
	logic [DW-1:0]                       sq_rad;
	logic [ptsa_pkg::ROOT_W-1:0]         sq_root;
	logic                                cord_start, cord_done, sq_start, sq_done, done_q;
	logic                                accept, cfg_wr;
	logic [15:0]                         pan_c, tilt_c;
	ptsa_pkg::result_t                   result_q;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == ptsa_pkg::REG_PLANE_DISTANCE);
	assign prdata = (paddr[2:2] == ptsa_pkg::REG_PLANE_DISTANCE) ? {16'd0, dist_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= ptsa_pkg::DIST_RESET;
		end else if (cfg_wr) begin
			dist_q <= pwdata[15:0];
		end
	end

	// input beat, bits above POSITION_WIDTH dropped
	assign accept = start && !busy;
	assign x_raw  = DW'($unsigned(target.x_position));
	assign y_raw  = DW'($unsigned(target.y_position));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_SQR;
				ST_SQR:  state_q <= ST_ROOT;
				ST_ROOT: state_q <= ST_WAIT;
				ST_WAIT: if (sq_done) state_q <= ST_TILT;
				ST_TILT: if (cord_done) state_q <= ST_MAP;
				ST_MAP: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

	// shared CORDIC: pan from ST_SQR, tilt once the root is ready
	assign cord_start = (state_q == ST_SQR) || (state_q == ST_WAIT && sq_done);
	assign cord_x = (state_q == ST_SQR) ? (DW'(d_q) << ptsa_pkg::OPERAND_SHIFT)
	                                    : (DW'(sq_root) << ptsa_pkg::OPERAND_SHIFT);
	assign cord_y = (state_q == ST_SQR) ? (DW'(x_q) <<< ptsa_pkg::OPERAND_SHIFT)
	                                    : (DW'(y_q) <<< (ROOT_FRAC + ptsa_pkg::OPERAND_SHIFT));

	ptsa_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.x_init (cord_x),
		.y_init (cord_y),
		.done   (cord_done),
		.angle  (cord_angle)
	);

	// radius squared, scaled for the root
	assign sq_start = (state_q == ST_ROOT);
	assign sq_rad   = (DW'($unsigned(sqx_q)) + DW'(sqd_q)) << (2 * ROOT_FRAC);

	ptsa_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_rad),
		.done     (sq_done),
		.root     (sq_root)
	);

	// operand capture, squares, angle product
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= $signed(x_raw[PW-1:0]);
			y_q <= $signed(y_raw[PW-1:0]);
			d_q <= dist_q;
		end
		if (state_q == ST_SQR) begin
			sqx_q <= x_q * x_q;
			sqd_q <= d_q * d_q;
		end
		if (cord_done && state_q != ST_TILT) apan_q <= cord_angle;
		if (cord_done && state_q == ST_TILT) tprod_s1 <= DW'(cord_angle) * ptsa_pkg::TILT_GAIN;
	end

	// compare mapping, round half up, zero becomes one
	assign pan_sum = 48'(apan_q) * ptsa_pkg::PAN_GAIN + (48'sd1 <<< 31);
	assign tnum    = (64'sd1 <<< 47) - tprod_s1 - ptsa_pkg::TILT_BIAS;
	assign pan_c   = ptsa_pkg::CENTER_COMPARE + pan_sum[47:32];
	assign tilt_c  = ptsa_pkg::CENTER_COMPARE + tnum[63:48];

	always_ff @(posedge clk) begin
		if (state_q == ST_MAP) begin
			result_q.pan_compare  <= (pan_c == 16'd0) ? 16'd1 : pan_c;
			result_q.tilt_compare <= (tilt_c == 16'd0) ? 16'd1 : tilt_c;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	ap_done_from_map: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_MAP)) else $error("result beat out of sequence");
	ap_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.pan_compare != 16'd0 && result.tilt_compare != 16'd0))
		else $error("zero compare value delivered");
	ap_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy) else $error("accepted beat not held busy");
	ap_root_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> state_q == ST_WAIT) else $error("root finished outside wait");

endmodule
